[rtl/core/pipc_pkg.sv]
package pipc_pkg;

  // Register stages of the geometry front end: differences, products, sums.
  localparam int unsigned GeomStages = 3;
  // Register stages of each wide multiplier: square, fold, cross, rows, total.
  localparam int unsigned MulStages  = 5;
  // The last stage holds the decision and is the output register.
  localparam int unsigned NumStages  = GeomStages + MulStages + 1;

  // Sign information about the corner that travels alongside the wide products.
  typedef struct packed {
    logic pa_pos;   // arm BA lies strictly to the left of BQ
    logic pc_pos;   // arm BC lies strictly to the left of BQ
    logic dc_neg;   // projection of BC on BQ is negative
    logic dc_zero;  // projection of BC on BQ is zero
    logic da_neg;   // projection of BA on BQ is negative
    logic da_zero;  // projection of BA on BQ is zero
  } flags_t;

endpackage

[rtl/core/pipc_geom.sv]
module pipc_geom import pipc_pkg::*; #(
  parameter int unsigned CoordW = 32
) (
  input  logic                          clk_i,
  input  logic [GeomStages-1:0]         en_i,
  input  logic signed [CoordW-1:0]      a_x_i,
  input  logic signed [CoordW-1:0]      a_y_i,
  input  logic signed [CoordW-1:0]      b_x_i,
  input  logic signed [CoordW-1:0]      b_y_i,
  input  logic signed [CoordW-1:0]      c_x_i,
  input  logic signed [CoordW-1:0]      c_y_i,
  input  logic signed [CoordW-1:0]      q_x_i,
  input  logic signed [CoordW-1:0]      q_y_i,
  output flags_t                        flags_o,
  output logic [2*(CoordW+1)-1:0]       mag_a_o,
  output logic [2*(CoordW+1)-1:0]       mag_c_o,
  output logic [2*(CoordW+1)-1:0]       norm_a_o,
  output logic [2*(CoordW+1)-1:0]       norm_c_o
);

  localparam int unsigned DW = CoordW + 1;
  localparam int unsigned PW = 2 * DW;
  localparam int unsigned SW = PW + 1;

  logic signed [DW-1:0] bax_q, bay_q, bcx_q, bcy_q, bqx_q, bqy_q;

  logic signed [PW-1:0] cr_a1_q, cr_a2_q, cr_c1_q, cr_c2_q;
  logic signed [PW-1:0] dt_a1_q, dt_a2_q, dt_c1_q, dt_c2_q;
  logic signed [PW-1:0] nm_a1_q, nm_a2_q, nm_c1_q, nm_c2_q;

  logic signed [SW-1:0] cross_a, cross_c, dot_a, dot_c;
  logic [PW-1:0]        norm_a_d, norm_c_d, mag_a_d, mag_c_d;
  flags_t               flags_d;

  flags_t               flags_q;
  logic [PW-1:0]        mag_a_q, mag_c_q, norm_a_q, norm_c_q;

  // Edge vectors from the vertex B.
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      bax_q <= DW'(a_x_i) - DW'(b_x_i);
      bay_q <= DW'(a_y_i) - DW'(b_y_i);
      bcx_q <= DW'(c_x_i) - DW'(b_x_i);
      bcy_q <= DW'(c_y_i) - DW'(b_y_i);
      bqx_q <= DW'(q_x_i) - DW'(b_x_i);
      bqy_q <= DW'(q_y_i) - DW'(b_y_i);
    end
  end

  // All component products, one multiplier each.
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      cr_a1_q <= bqx_q * bay_q;
      cr_a2_q <= bqy_q * bax_q;
      cr_c1_q <= bqx_q * bcy_q;
      cr_c2_q <= bqy_q * bcx_q;
      dt_a1_q <= bax_q * bqx_q;
      dt_a2_q <= bay_q * bqy_q;
      dt_c1_q <= bcx_q * bqx_q;
      dt_c2_q <= bcy_q * bqy_q;
      nm_a1_q <= bax_q * bax_q;
      nm_a2_q <= bay_q * bay_q;
      nm_c1_q <= bcx_q * bcx_q;
      nm_c2_q <= bcy_q * bcy_q;
    end
  end

  always_comb begin
    cross_a  = SW'(cr_a1_q) - SW'(cr_a2_q);
    cross_c  = SW'(cr_c1_q) - SW'(cr_c2_q);
    dot_a    = SW'(dt_a1_q) + SW'(dt_a2_q);
    dot_c    = SW'(dt_c1_q) + SW'(dt_c2_q);
    norm_a_d = $unsigned(nm_a1_q) + $unsigned(nm_a2_q);
    norm_c_d = $unsigned(nm_c1_q) + $unsigned(nm_c2_q);
    mag_a_d  = dot_a[SW-1] ? PW'(-dot_a) : PW'(dot_a);
    mag_c_d  = dot_c[SW-1] ? PW'(-dot_c) : PW'(dot_c);

    flags_d.pa_pos  = !cross_a[SW-1] && (cross_a != '0);
    flags_d.pc_pos  = !cross_c[SW-1] && (cross_c != '0);
    flags_d.da_neg  = dot_a[SW-1];
    flags_d.da_zero = (dot_a == '0);
    flags_d.dc_neg  = dot_c[SW-1];
    flags_d.dc_zero = (dot_c == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      flags_q  <= flags_d;
      mag_a_q  <= mag_a_d;
      mag_c_q  <= mag_c_d;
      norm_a_q <= norm_a_d;
      norm_c_q <= norm_c_d;
    end
  end

  assign flags_o  = flags_q;
  assign mag_a_o  = mag_a_q;
  assign mag_c_o  = mag_c_q;
  assign norm_a_o = norm_a_q;
  assign norm_c_o = norm_c_q;

endmodule

[rtl/core/pipc_wmul.sv]
module pipc_wmul import pipc_pkg::*; #(
  parameter int unsigned LimbW = 33
) (
  input  logic                  clk_i,
  input  logic [MulStages-1:0]  en_i,
  input  logic [2*LimbW-1:0]    mag_i,
  input  logic [2*LimbW-1:0]    norm_i,
  output logic [6*LimbW-1:0]    prod_o
);

  // Computes mag * mag * norm exactly, one limb product per multiplier.
  localparam int unsigned PW   = 2 * LimbW;
  localparam int unsigned SqW  = 4 * LimbW;
  localparam int unsigned RowW = 5 * LimbW;
  localparam int unsigned TotW = 6 * LimbW;

  logic [PW-1:0]   pp00_q, pp01_q, pp11_q;
  logic [PW-1:0]   norm3_q, norm4_q;
  logic [SqW-1:0]  sq_q;
  logic [PW-1:0]   pp_d [4][2];
  logic [PW-1:0]   pp_q [4][2];
  logic [RowW-1:0] row_d [2];
  logic [RowW-1:0] row_q [2];
  logic [TotW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      pp00_q  <= PW'(mag_i[LimbW-1:0]) * PW'(mag_i[LimbW-1:0]);
      pp01_q  <= PW'(mag_i[LimbW-1:0]) * PW'(mag_i[PW-1:LimbW]);
      pp11_q  <= PW'(mag_i[PW-1:LimbW]) * PW'(mag_i[PW-1:LimbW]);
      norm3_q <= norm_i;
    end
  end

  // The cross term appears twice in the square, hence the extra shift.
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      sq_q    <= SqW'(pp00_q) + (SqW'(pp01_q) << (LimbW + 1)) + (SqW'(pp11_q) << PW);
      norm4_q <= norm3_q;
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 2; j++) begin
        pp_d[i][j] = PW'(sq_q[i*LimbW +: LimbW]) * PW'(norm4_q[j*LimbW +: LimbW]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      pp_q <= pp_d;
    end
  end

  always_comb begin
    for (int j = 0; j < 2; j++) begin
      row_d[j] = RowW'(pp_q[0][j])
               + (RowW'(pp_q[1][j]) << LimbW)
               + (RowW'(pp_q[2][j]) << (2 * LimbW))
               + (RowW'(pp_q[3][j]) << (3 * LimbW));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      row_q <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      prod_q <= TotW'(row_q[0]) + (TotW'(row_q[1]) << LimbW);
    end
  end

  assign prod_o = prod_q;

endmodule

[rtl/core/pipc_decide.sv]
module pipc_decide import pipc_pkg::*; #(
  parameter int unsigned ProdW = 198
) (
  input  logic               clk_i,
  input  logic [MulStages:0] en_i,
  input  flags_t             flags_i,
  input  logic [ProdW-1:0]   lhs_i,
  input  logic [ProdW-1:0]   rhs_i,
  output logic               inside_o
);

  // lhs is dc^2 * |BA|^2 and rhs is da^2 * |BC|^2; their order decides
  // which arm has the larger cosine when both projections share a sign.
  flags_t         flags_q [MulStages];
  flags_t         f;
  logic [1:0]     rank_c, rank_a;
  logic           c_lt;
  logic           inside_d;
  logic           inside_q;

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < MulStages; s++) begin
      if (en_i[s]) begin
        flags_q[s] <= (s == 0) ? flags_i : flags_q[(s == 0) ? 0 : s - 1];
      end
    end
  end

  always_comb begin
    f      = flags_q[MulStages-1];
    // Order of the projection signs: negative, zero, positive.
    rank_c = f.dc_zero ? 2'd1 : (f.dc_neg ? 2'd0 : 2'd2);
    rank_a = f.da_zero ? 2'd1 : (f.da_neg ? 2'd0 : 2'd2);
    priority if (rank_c != rank_a) begin
      c_lt = (rank_c < rank_a);
    end else if (f.dc_zero) begin
      c_lt = 1'b0;
    end else if (f.dc_neg) begin
      c_lt = (lhs_i > rhs_i);
    end else begin
      c_lt = (lhs_i < rhs_i);
    end
    if (f.pa_pos != f.pc_pos) begin
      inside_d = f.pa_pos;
    end else begin
      inside_d = f.pa_pos ? c_lt : !c_lt;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[MulStages]) begin
      inside_q <= inside_d;
    end
  end

  assign inside_o = inside_q;

endmodule

[rtl/core/point_in_polygon_corner_test_unit.sv]
// Point-in-corner test for one corner ABC of a counter-clockwise contour.
// Input channel: in_valid_i / in_ready_o carry one request, the points A, B,
// C and Q as signed coordinates of COORD_BITS bits. Output channel:
// out_valid_o / out_ready_i carry one result per request, inside_res_o,
// which is 1 when Q lies inside the corner at B.
// Throughput is one request per cycle while the receiver takes results. Three
// stages form the edge vectors, their products and the cross and dot sums,
// five stages form the exact products dc^2*|BA|^2 and da^2*|BC|^2 out of
// limb multipliers, and the last stage compares them and holds the result.
// Every stage has its own valid bit and advances when it is empty or its
// successor advances, so bubbles close up and a request is taken whenever
// any stage has room. When the receiver stalls, results back up stage by
// stage and in_ready_o falls only once all nine stages are full.
// Reset clears the valid bits only; the data registers are not reset.
module point_in_polygon_corner_test_unit import pipc_pkg::*; #(
  parameter int unsigned COORD_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [COORD_BITS-1:0] a_x_i,
  input  logic signed [COORD_BITS-1:0] a_y_i,
  input  logic signed [COORD_BITS-1:0] b_x_i,
  input  logic signed [COORD_BITS-1:0] b_y_i,
  input  logic signed [COORD_BITS-1:0] c_x_i,
  input  logic signed [COORD_BITS-1:0] c_y_i,
  input  logic signed [COORD_BITS-1:0] q_x_i,
  input  logic signed [COORD_BITS-1:0] q_y_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         inside_res_o
);

  // Differences need one bit more than the coordinates; that is the limb
  // width of every multiplier in the design.
  localparam int unsigned LimbW = COORD_BITS + 1;
  localparam int unsigned PW    = 2 * LimbW;
  localparam int unsigned TotW  = 6 * LimbW;

  logic [NumStages-1:0] valid_q;
  logic [NumStages-1:0] valid_d;
  logic [NumStages:0]   en;

  flags_t               flags;
  logic [PW-1:0]        mag_a, mag_c, norm_a, norm_c;
  logic [TotW-1:0]      lhs, rhs;

  // A stage may load when it is empty or when its contents move on.
  always_comb begin
    en[NumStages] = out_ready_i;
    for (int s = NumStages - 1; s >= 0; s--) begin
      en[s] = !valid_q[s] || en[s+1];
    end
  end

  assign valid_d = {valid_q[NumStages-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int s = 0; s < NumStages; s++) begin
        if (en[s]) begin
          valid_q[s] <= valid_d[s];
        end
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = valid_q[NumStages-1];

  // Edge vectors, component products, cross signs, dot products and norms.
  pipc_geom #(
    .CoordW (COORD_BITS)
  ) u_geom (
    .clk_i    (clk_i),
    .en_i     (en[GeomStages-1:0]),
    .a_x_i    (a_x_i),
    .a_y_i    (a_y_i),
    .b_x_i    (b_x_i),
    .b_y_i    (b_y_i),
    .c_x_i    (c_x_i),
    .c_y_i    (c_y_i),
    .q_x_i    (q_x_i),
    .q_y_i    (q_y_i),
    .flags_o  (flags),
    .mag_a_o  (mag_a),
    .mag_c_o  (mag_c),
    .norm_a_o (norm_a),
    .norm_c_o (norm_c)
  );

  // The cosine comparison is squared and cross-multiplied, so each side is
  // the square of one projection times the squared length of the other arm.
  pipc_wmul #(
    .LimbW (LimbW)
  ) u_mul_lhs (
    .clk_i  (clk_i),
    .en_i   (en[GeomStages +: MulStages]),
    .mag_i  (mag_c),
    .norm_i (norm_a),
    .prod_o (lhs)
  );

  pipc_wmul #(
    .LimbW (LimbW)
  ) u_mul_rhs (
    .clk_i  (clk_i),
    .en_i   (en[GeomStages +: MulStages]),
    .mag_i  (mag_a),
    .norm_i (norm_c),
    .prod_o (rhs)
  );

  // The sign flags ride alongside the multipliers and meet the products in
  // the final stage, which also serves as the output register.
  pipc_decide #(
    .ProdW (TotW)
  ) u_decide (
    .clk_i    (clk_i),
    .en_i     (en[NumStages-1:GeomStages]),
    .flags_i  (flags),
    .lhs_i    (lhs),
    .rhs_i    (rhs),
    .inside_o (inside_res_o)
  );

  // A ready receiver always lets a new request in.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input blocked although the receiver is ready");

  // Back-pressure reaches the input only through a stalled output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i && valid_q[0]))
    else $error("input blocked without a stalled output");

  // An accepted request occupies the first stage on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> valid_q[0])
    else $error("accepted request lost at the first stage");

  // A full stage that cannot move keeps its request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q[GeomStages] && !en[GeomStages]) |=> valid_q[GeomStages])
    else $error("stalled request dropped inside the multiplier pipeline");

endmodule
